[rtl/core/trlc_pkg.sv]
// ----------------------------------------------------------------------------
// trlc_pkg
// Shared types and constants of the text record length converter.
// ----------------------------------------------------------------------------
package trlc_pkg;

  localparam int unsigned ColW     = 16;  // column counters
  localparam int unsigned RunW     = 15;  // space run and record length
  localparam int unsigned CharW    = 8;
  localparam int unsigned CountW   = 16;  // overflow counter
  localparam int unsigned FlagW    = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;

  // mode flag bit positions
  localparam int unsigned FlagPad   = 0;
  localparam int unsigned FlagWrap  = 1;
  localparam int unsigned FlagCount = 2;

  localparam logic [CharW-1:0]  CharNl       = 8'd10;
  localparam logic [CharW-1:0]  CharSp       = 8'd32;
  localparam logic [RunW-1:0]   RecLenReset  = 15'd1024;
  localparam logic [FlagW-1:0]  ModeReset    = 3'd0;
  localparam logic [CountW-1:0] CountMax     = 16'hFFFF;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRecordLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegModeFlags    = 2'd1;

  typedef enum logic {
    ActData = 1'b0,
    ActEnd  = 1'b1
  } action_e;

  // One queued command: a first result and an optional second one
  // (the second always carries a plain character with no space run).
  typedef struct packed {
    logic [RunW-1:0]   run;
    logic [CharW-1:0]  chr0;
    logic              present0;
    logic [CountW-1:0] total;
    logic              report;
    logic              two;
    logic [CharW-1:0]  chr1;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic valid;   // head entry present
    cmd_t cmd;     // head entry
  } head_t;

endpackage

[rtl/core/trlc_intf.sv]
// ----------------------------------------------------------------------------
// trlc interfaces
// Input, result and configuration channels of the record length converter.
// ----------------------------------------------------------------------------
interface trlc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [trlc_pkg::CharW-1:0]  in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface trlc_out_if;
  logic                        valid;
  logic                        ready;
  logic [trlc_pkg::RunW-1:0]   space_run;
  logic [trlc_pkg::CharW-1:0]  out_char;
  logic                        char_present;
  logic [trlc_pkg::CountW-1:0] overflow_total;
  logic                        report_valid;
  logic                        final_of_run;

  modport source (output valid, output space_run, output out_char, output char_present,
                  output overflow_total, output report_valid, output final_of_run,
                  input ready);
  modport sink   (input valid, input space_run, input out_char, input char_present,
                  input overflow_total, input report_valid, input final_of_run,
                  output ready);
endinterface

interface trlc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [trlc_pkg::CfgIdxW-1:0]  index;
  logic [trlc_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/trlc_front.sv]
// ----------------------------------------------------------------------------
// trlc_front
// Accepts items, holds the line state and config, and turns each item into
// at most one queued command.
// ----------------------------------------------------------------------------
module trlc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  trlc_in_if.sink             in_ch,
  trlc_cfg_if.sink            cfg_ch,
  input  logic                full_i,
  output trlc_pkg::push_t     push_o
);

  logic [trlc_pkg::RunW-1:0]   rec_len_q;
  logic [trlc_pkg::FlagW-1:0]  mode_q;
  logic [trlc_pkg::ColW-1:0]   emit_col_q, emit_col_d;
  logic [trlc_pkg::ColW-1:0]   in_col_q, in_col_d;
  logic [trlc_pkg::CountW-1:0] ovf_q, ovf_d;

  logic                        accept;
  logic [trlc_pkg::ColW-1:0]   rec_len_w;
  logic [trlc_pkg::ColW-1:0]   pad_run;
  logic [trlc_pkg::ColW-1:0]   gap_run;
  logic                        is_space;
  logic [trlc_pkg::CountW-1:0] ovf_inc;
  trlc_pkg::push_t             push;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !full_i;
  assign accept       = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_len_q <= trlc_pkg::RecLenReset;
      mode_q    <= trlc_pkg::ModeReset;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        trlc_pkg::RegRecordLength: rec_len_q <= cfg_ch.data;
        trlc_pkg::RegModeFlags:    mode_q    <= cfg_ch.data[trlc_pkg::FlagW-1:0];
        default: ;
      endcase
    end
  end

  // run lengths
  assign rec_len_w = {1'b0, rec_len_q};
  assign pad_run   = (emit_col_q < rec_len_w) ? (rec_len_w - emit_col_q) : '0;
  assign gap_run   = (emit_col_q < in_col_q) ? (in_col_q - emit_col_q) : '0;
  assign is_space  = (in_ch.in_byte == trlc_pkg::CharSp);
  assign ovf_inc   = (ovf_q != trlc_pkg::CountMax) ? (ovf_q + 1'b1) : ovf_q;

  // classify the item
  always_comb begin
    emit_col_d = emit_col_q;
    in_col_d   = in_col_q;
    ovf_d      = ovf_q;
    push       = '0;
    if (trlc_pkg::action_e'(in_ch.action) == trlc_pkg::ActEnd) begin
      push.valid      = mode_q[trlc_pkg::FlagCount] && (ovf_q != '0);
      push.cmd.total  = ovf_q;
      push.cmd.report = 1'b1;
      emit_col_d      = '0;
      in_col_d        = '0;
      ovf_d           = '0;
    end else if (in_ch.in_byte == trlc_pkg::CharNl) begin
      push.valid        = 1'b1;
      push.cmd.run      = mode_q[trlc_pkg::FlagPad] ? pad_run[trlc_pkg::RunW-1:0] : '0;
      push.cmd.chr0     = trlc_pkg::CharNl;
      push.cmd.present0 = 1'b1;
      emit_col_d        = '0;
      in_col_d          = '0;
    end else if (in_col_q < rec_len_w) begin
      if (!is_space) begin
        push.valid        = 1'b1;
        push.cmd.run      = gap_run[trlc_pkg::RunW-1:0];
        push.cmd.chr0     = in_ch.in_byte;
        push.cmd.present0 = 1'b1;
        emit_col_d        = in_col_q + 1'b1;
      end
      in_col_d = in_col_q + 1'b1;
    end else if (mode_q[trlc_pkg::FlagWrap]) begin
      // padded newline, then the byte opens a new line
      push.valid        = 1'b1;
      push.cmd.run      = pad_run[trlc_pkg::RunW-1:0];
      push.cmd.chr0     = trlc_pkg::CharNl;
      push.cmd.present0 = 1'b1;
      push.cmd.two      = !is_space;
      push.cmd.chr1     = in_ch.in_byte;
      emit_col_d        = is_space ? trlc_pkg::ColW'(0) : trlc_pkg::ColW'(1);
      in_col_d          = trlc_pkg::ColW'(1);
      ovf_d             = ovf_inc;
    end else begin
      ovf_d = ovf_inc;
    end
  end

  // line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_col_q <= '0;
      in_col_q   <= '0;
      ovf_q      <= '0;
    end else if (accept) begin
      emit_col_q <= emit_col_d;
      in_col_q   <= in_col_d;
      ovf_q      <= ovf_d;
    end
  end

  always_comb begin
    push_o       = push;
    push_o.valid = push.valid && accept;
  end

  // emitted columns never run ahead of consumed columns
  a_col_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_col_q <= in_col_q)
    else $error("trlc_front: emitted column ahead of input column");

  // a saturated count only leaves its ceiling on end of stream
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovf_q == trlc_pkg::CountMax) && !(accept && in_ch.action) |=>
      ovf_q == trlc_pkg::CountMax)
    else $error("trlc_front: overflow count left saturation");

endmodule

[rtl/core/trlc_queue.sv]
// ----------------------------------------------------------------------------
// trlc_queue
// Short shifting command queue between the front and back parts; the head
// always sits in entry zero.
// ----------------------------------------------------------------------------
module trlc_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  trlc_pkg::push_t push_i,
  input  logic            pop_i,
  output logic            full_o,
  output trlc_pkg::head_t head_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  trlc_pkg::cmd_t  ent_q [Depth];
  trlc_pkg::cmd_t  ent_d [Depth];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = ent_q[0];
  assign do_pop       = pop_i && head_o.valid;

  // entries shift down on a pop; a push lands behind the last live entry
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (do_pop) begin
        if (push_i.valid && (CntW'(i) == cnt_q - 1'b1)) begin
          ent_d[i] = push_i.cmd;
        end else if (i < Depth - 1) begin
          ent_d[i] = ent_q[(i < Depth - 1) ? i + 1 : i];
        end else begin
          ent_d[i] = ent_q[i];
        end
      end else if (push_i.valid && (CntW'(i) == cnt_q)) begin
        ent_d[i] = push_i.cmd;
      end else begin
        ent_d[i] = ent_q[i];
      end
    end
    cnt_d = cnt_q + CntW'(push_i.valid) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.valid && full_o))
    else $error("trlc_queue: push into full queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("trlc_queue: count beyond depth");

endmodule

[rtl/core/trlc_back.sv]
// ----------------------------------------------------------------------------
// trlc_back
// Unpacks queued commands into result transfers through an output register.
// ----------------------------------------------------------------------------
module trlc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  trlc_pkg::head_t head_i,
  output logic            pop_o,
  trlc_out_if.source      out_ch
);

  logic                        out_valid_q;
  logic                        second_q;    // next result is the second one
  logic [trlc_pkg::RunW-1:0]   run_q;
  logic [trlc_pkg::CharW-1:0]  chr_q;
  logic                        present_q;
  logic [trlc_pkg::CountW-1:0] total_q;
  logic                        report_q;
  logic                        final_q;
  logic                        load;

  assign load  = !out_valid_q || out_ch.ready;
  assign pop_o = load && head_i.valid && (second_q || !head_i.cmd.two);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else if (load) begin
      out_valid_q <= head_i.valid;
      if (head_i.valid) begin
        second_q <= !second_q && head_i.cmd.two;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load && head_i.valid) begin
      if (second_q) begin
        run_q     <= '0;
        chr_q     <= head_i.cmd.chr1;
        present_q <= 1'b1;
        total_q   <= '0;
        report_q  <= 1'b0;
        final_q   <= 1'b1;
      end else begin
        run_q     <= head_i.cmd.run;
        chr_q     <= head_i.cmd.chr0;
        present_q <= head_i.cmd.present0;
        total_q   <= head_i.cmd.total;
        report_q  <= head_i.cmd.report;
        final_q   <= !head_i.cmd.two;
      end
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.space_run      = run_q;
  assign out_ch.out_char       = chr_q;
  assign out_ch.char_present   = present_q;
  assign out_ch.overflow_total = total_q;
  assign out_ch.report_valid   = report_q;
  assign out_ch.final_of_run   = final_q;

  // the second half of a command keeps its entry at the head
  a_second_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> head_i.valid && head_i.cmd.two)
    else $error("trlc_back: second result without its command");

endmodule

[rtl/core/text_record_length_converter_top.sv]
// ----------------------------------------------------------------------------
// text_record_length_converter_top
// Reshapes a byte stream of text lines to a record length. One item is taken
// per cycle while the command queue is not full; a front part updates the
// column state and queues a command, a back part plays the commands out as
// result transfers through an output register. A wrapped non-space byte
// gives two results, items with no result (held spaces, dropped bytes) none,
// all others one. The QueueDepth-entry command queue absorbs those bursts
// and output stalls. The user writes configuration through the cfg channel
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module text_record_length_converter_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  trlc_in_if.sink     in_ch,
  trlc_cfg_if.sink    cfg_ch,
  trlc_out_if.source  out_ch
);

  trlc_pkg::push_t push;
  trlc_pkg::head_t head;
  logic            full;
  logic            pop;

  trlc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .full_i (full),
    .push_o (push)
  );

  trlc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  trlc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_ch (out_ch)
  );

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of the text record length converter. A directed table of
// stimulus comes first: register extremes, held and dropped blanks, wraps,
// padding, count reports. It is followed by random text phases under random
// register settings and a run of dropped bytes closed by a count report.
// Every accepted item runs through a local line-state model. Each result
// transfer is checked field by field against the oldest expected result.
// Both sides stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int Period      = 12;
  localparam int DrainCycles = 8;      // output register plus a short queue
  localparam int HoldCycles  = 400;    // long receiver hold-off
  localparam int RandomItems = 1620;
  localparam int DropItems   = 200;    // dropped bytes counted for the report
  localparam int NumRows     = 39;

  // one result transfer
  typedef struct packed {
    logic [trlc_pkg::RunW-1:0]   run;
    logic [trlc_pkg::CharW-1:0]  chr;
    logic                        present;
    logic [trlc_pkg::CountW-1:0] total;
    logic                        report;
    logic                        last;
  } text_out_t;

  typedef enum logic [1:0] {RowCfg, RowItem, RowWant} row_kind_e;

  // RowCfg: a = register, b = value. RowItem/RowWant: a = action, b = byte.
  // RowWant carries n typed results (0 or 1); nonzero total means a report.
  typedef struct packed {
    row_kind_e kind;
    int        a;
    int        b;
    int        n;
    int        run;
    int        chr;
    int        total;
  } script_row_t;

  localparam script_row_t Script [NumRows] = '{
    // after reset: record 1024, no flags
    '{RowWant, trlc_pkg::ActData, "A",              1, 0, "A",              0},
    '{RowWant, trlc_pkg::ActData, trlc_pkg::CharSp, 0, 0, 0,                0},
    '{RowWant, trlc_pkg::ActData, "B",              1, 1, "B",              0},
    '{RowWant, trlc_pkg::ActData, trlc_pkg::CharNl, 1, 0, trlc_pkg::CharNl, 0},
    '{RowWant, trlc_pkg::ActData, 8'h00,            1, 0, 8'h00,            0},
    '{RowWant, trlc_pkg::ActData, 8'hFF,            1, 0, 8'hFF,            0},
    '{RowWant, trlc_pkg::ActEnd,  8'hFF,            0, 0, 0,                0},
    // short record, all flags: wrap of a byte and of a blank, padded newline
    '{RowCfg,  trlc_pkg::RegRecordLength, 3, 0, 0, 0, 0},
    '{RowCfg,  trlc_pkg::RegModeFlags,    7, 0, 0, 0, 0},
    '{RowItem, trlc_pkg::ActData, "a",              0, 0, 0,                0},
    '{RowItem, trlc_pkg::ActData, "b",              0, 0, 0,                0},
    '{RowItem, trlc_pkg::ActData, "c",              0, 0, 0,                0},
    '{RowItem, trlc_pkg::ActData, "d",              0, 0, 0,                0},
    '{RowWant, trlc_pkg::ActData, trlc_pkg::CharNl, 1, 2, trlc_pkg::CharNl, 0},
    '{RowItem, trlc_pkg::ActData, trlc_pkg::CharSp, 0, 0, 0,                0},
    '{RowItem, trlc_pkg::ActData, trlc_pkg::CharSp, 0, 0, 0,                0},
    '{RowItem, trlc_pkg::ActData, trlc_pkg::CharSp, 0, 0, 0,                0},
    '{RowItem, trlc_pkg::ActData, trlc_pkg::CharSp, 0, 0, 0,                0},
    '{RowItem, trlc_pkg::ActEnd,  8'h00,            0, 0, 0,                0},
    // zero record length with wrap: every byte starts a new line
    '{RowCfg,  trlc_pkg::RegRecordLength, 0, 0, 0, 0, 0},
    '{RowCfg,  trlc_pkg::RegModeFlags,    6, 0, 0, 0, 0},
    '{RowItem, trlc_pkg::ActData, "x",              0, 0, 0,                0},
    '{RowItem, trlc_pkg::ActData, trlc_pkg::CharNl, 0, 0, 0,                0},
    '{RowWant, trlc_pkg::ActEnd,  8'h00,            1, 0, 0,                1},
    // largest record, padded newline
    '{RowCfg,  trlc_pkg::RegRecordLength, 32767, 0, 0, 0, 0},
    '{RowCfg,  trlc_pkg::RegModeFlags,    1,     0, 0, 0, 0},
    '{RowItem, trlc_pkg::ActData, "z",              0, 0,     0,                0},
    '{RowWant, trlc_pkg::ActData, trlc_pkg::CharNl, 1, 32766, trlc_pkg::CharNl, 0},
    // dropped byte, then count report
    '{RowCfg,  trlc_pkg::RegRecordLength, 1, 0, 0, 0, 0},
    '{RowCfg,  trlc_pkg::RegModeFlags,    4, 0, 0, 0, 0},
    '{RowWant, trlc_pkg::ActData, "q",              1, 0, "q",              0},
    '{RowWant, trlc_pkg::ActData, "r",              0, 0, 0,                0},
    '{RowWant, trlc_pkg::ActEnd,  8'h00,            1, 0, 0,                1},
    // record lowered below the emitted columns: no padding
    '{RowCfg,  trlc_pkg::RegRecordLength, 4, 0, 0, 0, 0},
    '{RowCfg,  trlc_pkg::RegModeFlags,    1, 0, 0, 0, 0},
    '{RowItem, trlc_pkg::ActData, "a",              0, 0, 0,                0},
    '{RowItem, trlc_pkg::ActData, "b",              0, 0, 0,                0},
    '{RowCfg,  trlc_pkg::RegRecordLength, 1, 0, 0, 0, 0},
    '{RowWant, trlc_pkg::ActData, trlc_pkg::CharNl, 1, 0, trlc_pkg::CharNl, 0}
  };

  logic clk_i;
  logic rst_ni;

  trlc_in_if  in_if ();
  trlc_cfg_if cfg_if ();
  trlc_out_if out_if ();

  text_record_length_converter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_if),
    .cfg_ch (cfg_if),
    .out_ch (out_if)
  );

  // line state of the converter as seen from outside
  logic [trlc_pkg::ColW-1:0]   line_out_col;
  logic [trlc_pkg::ColW-1:0]   line_in_col;
  logic [trlc_pkg::CountW-1:0] overflow_seen;
  logic [trlc_pkg::RunW-1:0]   rec_len;
  logic [trlc_pkg::FlagW-1:0]  mode_bits;

  text_out_t results_due [$];
  text_out_t want;
  int        fail_count;
  bit        calm;       // no gaps on either side
  bit        hold_req;   // ask the receiver for a long hold-off
  int        stall_left;
  int        hold_left;

  initial clk_i = 1'b0;
  always #(Period / 2) clk_i = ~clk_i;

  // random gap: mostly none, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [trlc_pkg::RunW-1:0] pick_rec_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 26) return trlc_pkg::RunW'($urandom_range(17, 32767));
    return trlc_pkg::RunW'($urandom_range(1, 16));
  endfunction

  // text-like mix: blanks, newlines, printable bytes, a few arbitrary ones, rare ends of stream
  task automatic pick_item(output trlc_pkg::action_e act,
                           output logic [trlc_pkg::CharW-1:0] chr);
    int r;
    r = $urandom_range(0, 99);
    act = trlc_pkg::ActData;
    chr = trlc_pkg::CharW'($urandom_range(33, 126));
    if (r < 2) begin
      act = trlc_pkg::ActEnd;
      chr = trlc_pkg::CharW'($urandom_range(0, 255));
    end else if (r < 12) begin
      chr = trlc_pkg::CharNl;
    end else if (r < 42) begin
      chr = trlc_pkg::CharSp;
    end else if (r >= 94) begin
      chr = trlc_pkg::CharW'($urandom_range(0, 255));
    end
  endtask

  // expected results of one accepted item; updates the line state
  task automatic convert_item(input trlc_pkg::action_e act,
                              input logic [trlc_pkg::CharW-1:0] chr,
                              output text_out_t res [2], output int n);
    logic [trlc_pkg::RunW-1:0] fill;
    fill = (line_out_col < trlc_pkg::ColW'(rec_len)) ?
           trlc_pkg::RunW'(trlc_pkg::ColW'(rec_len) - line_out_col) : '0;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (act == trlc_pkg::ActEnd) begin
      // report pending count, drop held blanks, clear everything
      if (mode_bits[trlc_pkg::FlagCount] && overflow_seen != '0) begin
        res[0].total  = overflow_seen;
        res[0].report = 1'b1;
        n = 1;
      end
      line_out_col  = '0;
      line_in_col   = '0;
      overflow_seen = '0;
    end else if (chr == trlc_pkg::CharNl) begin
      res[0].run     = mode_bits[trlc_pkg::FlagPad] ? fill : '0;
      res[0].chr     = trlc_pkg::CharNl;
      res[0].present = 1'b1;
      n = 1;
      line_out_col = '0;
      line_in_col  = '0;
    end else if (line_in_col < trlc_pkg::ColW'(rec_len)) begin
      // inside the record: blanks are held, others flush the held run
      if (chr != trlc_pkg::CharSp) begin
        res[0].run     = (line_out_col < line_in_col) ?
                         trlc_pkg::RunW'(line_in_col - line_out_col) : '0;
        res[0].chr     = chr;
        res[0].present = 1'b1;
        n = 1;
        line_out_col = line_in_col + 1'b1;
      end
      line_in_col = line_in_col + 1'b1;
    end else if (mode_bits[trlc_pkg::FlagWrap]) begin
      // padded newline, then the byte itself unless it is a blank
      res[0].run     = fill;
      res[0].chr     = trlc_pkg::CharNl;
      res[0].present = 1'b1;
      n = 1;
      line_out_col = '0;
      if (chr != trlc_pkg::CharSp) begin
        res[1].chr     = chr;
        res[1].present = 1'b1;
        n = 2;
        line_out_col = trlc_pkg::ColW'(1);
      end
      line_in_col = trlc_pkg::ColW'(1);
      if (overflow_seen != trlc_pkg::CountMax) overflow_seen = overflow_seen + 1'b1;
    end else begin
      if (overflow_seen != trlc_pkg::CountMax) overflow_seen = overflow_seen + 1'b1;
    end
    if (n > 0) res[n-1].last = 1'b1;
  endtask

  task automatic queue_results(input text_out_t res [2], input int n);
    for (int k = 0; k < n; k++) results_due.push_back(res[k]);
  endtask

  // offer one item after a random gap, wait for the transfer, predict
  task automatic offer_item(input trlc_pkg::action_e act,
                            input logic [trlc_pkg::CharW-1:0] chr,
                            output text_out_t res [2], output int n);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid   <= 1'b1;
    in_if.action  <= act;
    in_if.in_byte <= chr;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    convert_item(act, chr, res, n);
  endtask

  // stop offering and wait until every expected result has arrived
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [trlc_pkg::CfgIdxW-1:0] idx,
                           input logic [trlc_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == trlc_pkg::RegRecordLength) rec_len = trlc_pkg::RunW'(val);
    else if (idx == trlc_pkg::RegModeFlags) mode_bits = trlc_pkg::FlagW'(val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, got char %0d run %0d",
                 $time, out_if.out_char, out_if.space_run);
      end else begin
        want = results_due.pop_front();
        check_field("space_run", want.run, out_if.space_run);
        check_field("out_char", want.chr, out_if.out_char);
        check_field("char_present", want.present, out_if.char_present);
        check_field("overflow_total", want.total, out_if.overflow_total);
        check_field("report_valid", want.report, out_if.report_valid);
        check_field("final_of_run", want.last, out_if.final_of_run);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    stall_left   = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // run limit
  initial begin
    #(Period * 3000000);
    $display("== FAIL ==");
    $finish;
  end

  // stimulus
  initial begin
    script_row_t                row;
    text_out_t                  got [2];
    int                         n;
    int                         items_done;
    int                         phase;
    int                         len;
    trlc_pkg::action_e          act;
    logic [trlc_pkg::CharW-1:0] chr;

    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.action   = trlc_pkg::ActData;
    in_if.in_byte  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = trlc_pkg::RegRecordLength;
    cfg_if.data    = '0;
    rec_len        = trlc_pkg::RecLenReset;
    mode_bits      = trlc_pkg::ModeReset;
    line_out_col   = '0;
    line_in_col    = '0;
    overflow_seen  = '0;
    fail_count     = 0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    foreach (Script[i]) begin
      row = Script[i];
      if (row.kind == RowCfg) begin
        drain_results();
        write_reg(trlc_pkg::CfgIdxW'(row.a), trlc_pkg::CfgDataW'(row.b));
      end else begin
        offer_item(trlc_pkg::action_e'(row.a[0]), trlc_pkg::CharW'(row.b), got, n);
        if (row.kind == RowWant) begin
          n = row.n;
          got[0] = '0;
          got[0].last = 1'b1;
          if (row.total != 0) begin
            got[0].total  = trlc_pkg::CountW'(row.total);
            got[0].report = 1'b1;
          end else begin
            got[0].run     = trlc_pkg::RunW'(row.run);
            got[0].chr     = trlc_pkg::CharW'(row.chr);
            got[0].present = 1'b1;
          end
        end
        queue_results(got, n);
      end
    end

    // random text phases under random settings
    items_done = 0;
    phase      = 0;
    while (items_done < RandomItems) begin
      drain_results();
      calm = ($urandom_range(0, 3) == 0);
      write_reg(trlc_pkg::RegRecordLength, pick_rec_len());
      write_reg(trlc_pkg::RegModeFlags, trlc_pkg::CfgDataW'($urandom_range(0, 7)));
      if (phase == 2) begin
        // receiver holds off while items keep coming: queue fills, input stalls
        calm     = 1'b0;
        hold_req = 1'b1;
      end
      len = $urandom_range(40, 120);
      for (int k = 0; k < len; k++) begin
        // sender waits mid-phase until the output side has caught up
        if (phase == 5 && k == len / 2) drain_results();
        pick_item(act, chr);
        offer_item(act, chr, got, n);
        queue_results(got, n);
        items_done++;
      end
      phase++;
    end

    // dropped bytes: zero record, no wrap, count report
    drain_results();
    calm = 1'b1;
    write_reg(trlc_pkg::RegRecordLength, '0);
    write_reg(trlc_pkg::RegModeFlags, trlc_pkg::CfgDataW'(1 << trlc_pkg::FlagCount));
    for (int k = 0; k < DropItems; k++) begin
      chr = trlc_pkg::CharW'($urandom_range(0, 255));
      if (chr == trlc_pkg::CharNl) chr = trlc_pkg::CharSp;
      offer_item(trlc_pkg::ActData, chr, got, n);
      queue_results(got, n);
    end
    calm = 1'b0;
    offer_item(trlc_pkg::ActEnd, trlc_pkg::CharW'($urandom_range(0, 255)), got, n);
    queue_results(got, n);

    drain_results();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
